// File: rtl/wbfm_pkg.sv
// shared types and constants of the windowed bit rate and frame rate meter
`default_nettype none

package wbfm_pkg;

    localparam int CMD_W        = 3;
    localparam int LEN_W        = 24;
    localparam int KIND_W       = 3;
    localparam int BIN_BYTES_W  = 32;
    localparam int BIN_FRAMES_W = 24;
    localparam int TOTAL_W      = 48;
    localparam int EVT_W        = 32;
    localparam int WIN_BYTES_W  = 35;
    localparam int WIN_FRAMES_W = 27;
    localparam int BITRATE_W    = 32;
    localparam int FRAMERATE_W  = 33;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 264;
    localparam int OUT_DEPTH    = 8;
    localparam int DIV_CHUNK_W  = 25;
    localparam int DIV_STAGES   = 4;

    // 8 bits * 1000 ms * 2^16 / 2^20 and 1000 ms * 2^8
    localparam int BITRATE_NUM   = 500;
    localparam int FRAMERATE_NUM = 256000;

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME  = 3'd0,
        CMD_TICK   = 3'd1,
        CMD_EVENT  = 3'd2,
        CMD_SENSOR = 3'd3,
        CMD_LOST   = 3'd4,
        CMD_STOP   = 3'd5,
        CMD_RESET  = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [BIN_BYTES_W-1:0]  bytes;
        logic [BIN_FRAMES_W-1:0] frames;
    } bin_t;

    typedef struct packed {
        logic [WIN_BYTES_W-1:0]  window_bytes;
        logic [WIN_FRAMES_W-1:0] window_frames;
        logic [TOTAL_W-1:0]      frame_count;
        logic [TOTAL_W-1:0]      byte_count;
        logic [EVT_W-1:0]        event_count;
        logic                    running;
        logic                    bad_sensor;
        logic                    connection_lost;
    } side_t;

endpackage

`default_nettype wire

// File: rtl/wbfm_div.sv
// pipelined division of a scaled count by a constant through a reciprocal multiply
`default_nettype none

module wbfm_div
    import wbfm_pkg::*;
#(
    parameter int IN_W  = 35,
    parameter int NUM   = 500,
    parameter int DEN   = 7000,
    parameter int OUT_W = 32
) (
    input  wire logic             aclk,
    input  wire logic [IN_W-1:0]  value,
    output logic      [OUT_W-1:0] quotient
);

    localparam int NUM_W = $clog2(NUM + 1);
    localparam int X_W   = IN_W + NUM_W;
    localparam int SH    = $clog2(DEN);
    localparam int K     = X_W + SH;
    localparam int CH    = DIV_CHUNK_W;
    localparam logic [127:0] RECIP = ((128'd1 << K) + 128'(DEN) - 128'd1) / 128'(DEN);
    localparam logic [NUM_W-1:0] NUM_C = NUM_W'(NUM);
    localparam logic [2*CH-1:0] M_C  = (2*CH)'(RECIP);
    localparam logic [CH-1:0]   M_LO = M_C[CH-1:0];
    localparam logic [CH-1:0]   M_HI = M_C[2*CH-1:CH];
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    logic [2*CH-1:0] x_next;
    logic [2*CH-1:0] x_reg;
    logic [2*CH-1:0] pp_ll_reg;
    logic [2*CH-1:0] pp_lh_reg;
    logic [2*CH-1:0] pp_hl_reg;
    logic [2*CH-1:0] pp_hh_reg;
    logic [2*CH-1:0] ll_reg;
    logic [2*CH-1:0] hh_reg;
    logic [2*CH:0]   mid_reg;
    logic [4*CH-1:0] full;
    logic [4*CH-1:0] q;
    logic [OUT_W-1:0] quot_reg;

    assign x_next = (2*CH)'(value) * (2*CH)'(NUM_C);

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        pp_ll_reg <= (2*CH)'(x_reg[CH-1:0]) * (2*CH)'(M_LO);
        pp_lh_reg <= (2*CH)'(x_reg[CH-1:0]) * (2*CH)'(M_HI);
        pp_hl_reg <= (2*CH)'(x_reg[2*CH-1:CH]) * (2*CH)'(M_LO);
        pp_hh_reg <= (2*CH)'(x_reg[2*CH-1:CH]) * (2*CH)'(M_HI);
        mid_reg   <= (2*CH+1)'(pp_lh_reg) + (2*CH+1)'(pp_hl_reg);
        ll_reg    <= pp_ll_reg;
        hh_reg    <= pp_hh_reg;
        quot_reg  <= (q > (4*CH)'(OUT_MAX)) ? OUT_MAX : OUT_W'(q);
    end

    assign full = {hh_reg, ll_reg} + ((4*CH)'(mid_reg) << CH);
    assign q    = full >> K;

    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: rtl/wbfm_core.sv
// bin and event memories with read-modify-write, window sums, totals and flags
`default_nettype none

module wbfm_core
    import wbfm_pkg::*;
#(
    parameter int BINS        = 8,
    parameter int EVENT_KINDS = 8,
    parameter int SB_W        = 35,
    parameter int SF_W        = 27
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic [CMD_W-1:0]  in_cmd,
    input  wire logic [LEN_W-1:0]  in_len,
    input  wire logic [KIND_W-1:0] in_kind,
    output logic                   out_valid,
    output logic      [SB_W-1:0]   out_sum_bytes,
    output logic      [SF_W-1:0]   out_sum_frames,
    output side_t                  out_side
);

    localparam int BIN_AW = $clog2(BINS);
    localparam int EK_AW  = (EVENT_KINDS > 1) ? $clog2(EVENT_KINDS) : 1;
    localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(BINS - 1);
    localparam logic [WIN_BYTES_W-1:0]  WB_MAX = '1;
    localparam logic [WIN_FRAMES_W-1:0] WF_MAX = '1;

    // accept side state
    logic               run_reg, run_next;
    logic               sensor_reg, sensor_next;
    logic               lost_reg, lost_next;
    logic [TOTAL_W-1:0] ftotal_reg, ftotal_next;
    logic [TOTAL_W-1:0] btotal_reg, btotal_next;
    logic [BIN_AW-1:0]  cur_reg, cur_next;
    logic               clear_all;

    cmd_t               cmd;
    logic [BIN_AW-1:0]  nxt;
    logic [EK_AW-1:0]   kidx;
    logic               kind_ok;
    logic               act_frame;
    logic               act_tick;
    logic               act_event;
    logic [TOTAL_W:0]   btotal_sum;

    // memories
    bin_t               bin_mem [BINS];
    logic [BINS-1:0]    bin_vld_reg;
    bin_t               rd_a_reg;
    bin_t               rd_b_reg;
    logic               rd_a_vld_reg;
    logic               rd_b_vld_reg;
    logic [EVT_W-1:0]   evt_mem [EVENT_KINDS];
    logic [EVENT_KINDS-1:0] evt_vld_reg;
    logic [EVT_W-1:0]   ev_rd_reg;
    logic               ev_rd_vld_reg;

    // last write, for forwarding
    logic               bin_last_vld_reg;
    logic [BIN_AW-1:0]  bin_last_addr_reg;
    bin_t               bin_last_data_reg;
    logic               evt_last_vld_reg;
    logic [EK_AW-1:0]   evt_last_addr_reg;
    logic [EVT_W-1:0]   evt_last_data_reg;

    // update stage
    logic               p1_vld_reg;
    logic               p1_frame_reg;
    logic               p1_tick_reg;
    logic               p1_event_reg;
    logic               p1_clear_reg;
    logic               p1_kind_ok_reg;
    logic [BIN_AW-1:0]  p1_cur_reg;
    logic [BIN_AW-1:0]  p1_nxt_reg;
    logic [EK_AW-1:0]   p1_kidx_reg;
    logic [LEN_W-1:0]   p1_len_reg;
    logic [TOTAL_W-1:0] p1_ftotal_reg;
    logic [TOTAL_W-1:0] p1_btotal_reg;
    logic               p1_run_reg;
    logic               p1_sensor_reg;
    logic               p1_lost_reg;

    bin_t               bin_a;
    bin_t               bin_b;
    bin_t               bin_upd;
    logic [BIN_BYTES_W:0] bin_bytes_sum;
    logic               bin_we;
    logic [BIN_AW-1:0]  bin_waddr;
    bin_t               bin_wdata;
    logic [EVT_W-1:0]   ev;
    logic [EVT_W-1:0]   ev_inc;
    logic               evt_we;

    logic [SB_W-1:0]    sum_b_reg, sum_b_next;
    logic [SF_W-1:0]    sum_f_reg, sum_f_next;
    logic [63:0]        sb_wide;
    logic [63:0]        sf_wide;
    side_t              side_next;
    side_t              side_reg;
    logic               out_vld_reg;

    assign cmd       = cmd_t'(in_cmd);
    assign nxt       = (cur_reg == LAST_BIN) ? '0 : cur_reg + BIN_AW'(1);
    assign kidx      = EK_AW'(in_kind);
    assign kind_ok   = (32'(in_kind) < 32'(EVENT_KINDS));
    assign act_frame = (cmd == CMD_FRAME) && run_reg && (in_len != '0);
    assign act_tick  = (cmd == CMD_TICK) && run_reg;
    assign act_event = (cmd == CMD_EVENT) && run_reg && kind_ok;
    assign btotal_sum = {1'b0, btotal_reg} + (TOTAL_W+1)'(in_len);

    always_comb begin
        run_next    = run_reg;
        sensor_next = sensor_reg;
        lost_next   = lost_reg;
        ftotal_next = ftotal_reg;
        btotal_next = btotal_reg;
        cur_next    = cur_reg;
        clear_all   = 1'b0;
        if (in_accept) begin
            unique case (cmd)
                CMD_FRAME: begin
                    if (act_frame) begin
                        ftotal_next = (ftotal_reg == '1) ? ftotal_reg
                                                         : ftotal_reg + TOTAL_W'(1);
                        btotal_next = btotal_sum[TOTAL_W] ? '1 : btotal_sum[TOTAL_W-1:0];
                        lost_next   = 1'b0;
                    end
                end
                CMD_TICK: begin
                    if (act_tick) begin
                        cur_next = nxt;
                    end
                end
                CMD_EVENT: begin
                end
                CMD_SENSOR: begin
                    if (run_reg) begin
                        sensor_next = 1'b1;
                    end
                end
                CMD_LOST: begin
                    lost_next = 1'b1;
                end
                CMD_STOP: begin
                    run_next = 1'b0;
                end
                CMD_RESET: begin
                    run_next    = 1'b1;
                    sensor_next = 1'b0;
                    lost_next   = 1'b0;
                    ftotal_next = '0;
                    btotal_next = '0;
                    cur_next    = '0;
                    clear_all   = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= 1'b1;
            sensor_reg <= 1'b0;
            lost_reg   <= 1'b0;
            ftotal_reg <= '0;
            btotal_reg <= '0;
            cur_reg    <= '0;
            p1_vld_reg <= 1'b0;
        end else begin
            run_reg    <= run_next;
            sensor_reg <= sensor_next;
            lost_reg   <= lost_next;
            ftotal_reg <= ftotal_next;
            btotal_reg <= btotal_next;
            cur_reg    <= cur_next;
            p1_vld_reg <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        p1_frame_reg   <= act_frame;
        p1_tick_reg    <= act_tick;
        p1_event_reg   <= act_event;
        p1_clear_reg   <= clear_all;
        p1_kind_ok_reg <= kind_ok;
        p1_cur_reg     <= cur_reg;
        p1_nxt_reg     <= nxt;
        p1_kidx_reg    <= kidx;
        p1_len_reg     <= in_len;
        p1_ftotal_reg  <= ftotal_next;
        p1_btotal_reg  <= btotal_next;
        p1_run_reg     <= run_next;
        p1_sensor_reg  <= sensor_next;
        p1_lost_reg    <= lost_next;
    end

    // bin entries, newest write wins over stale read data
    always_comb begin
        if (bin_last_vld_reg && (bin_last_addr_reg == p1_cur_reg)) begin
            bin_a = bin_last_data_reg;
        end else begin
            bin_a = rd_a_vld_reg ? rd_a_reg : '0;
        end
        if (bin_last_vld_reg && (bin_last_addr_reg == p1_nxt_reg)) begin
            bin_b = bin_last_data_reg;
        end else begin
            bin_b = rd_b_vld_reg ? rd_b_reg : '0;
        end
        if (evt_last_vld_reg && (evt_last_addr_reg == p1_kidx_reg)) begin
            ev = evt_last_data_reg;
        end else begin
            ev = ev_rd_vld_reg ? ev_rd_reg : '0;
        end
    end

    assign bin_bytes_sum  = {1'b0, bin_a.bytes} + (BIN_BYTES_W+1)'(p1_len_reg);
    assign bin_upd.bytes  = bin_bytes_sum[BIN_BYTES_W] ? '1 : bin_bytes_sum[BIN_BYTES_W-1:0];
    assign bin_upd.frames = (bin_a.frames == '1) ? bin_a.frames
                                                 : bin_a.frames + BIN_FRAMES_W'(1);
    assign bin_we    = p1_vld_reg && (p1_frame_reg || p1_tick_reg);
    assign bin_waddr = p1_tick_reg ? p1_nxt_reg : p1_cur_reg;
    assign bin_wdata = p1_tick_reg ? '0 : bin_upd;

    assign ev_inc = (ev == '1) ? ev : ev + EVT_W'(1);
    assign evt_we = p1_vld_reg && p1_event_reg;

    always_ff @(posedge aclk) begin
        if (bin_we) begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        rd_a_reg     <= bin_mem[cur_reg];
        rd_b_reg     <= bin_mem[nxt];
        rd_a_vld_reg <= bin_vld_reg[cur_reg];
        rd_b_vld_reg <= bin_vld_reg[nxt];
        if (evt_we) begin
            evt_mem[p1_kidx_reg] <= ev_inc;
        end
        ev_rd_reg     <= evt_mem[kidx];
        ev_rd_vld_reg <= evt_vld_reg[kidx];
        bin_last_addr_reg <= bin_waddr;
        bin_last_data_reg <= bin_wdata;
        evt_last_addr_reg <= p1_kidx_reg;
        evt_last_data_reg <= ev_inc;
    end

    // a reset command clears every entry at once
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            bin_vld_reg <= '0;
            evt_vld_reg <= '0;
        end else begin
            if (bin_we) begin
                bin_vld_reg[bin_waddr] <= 1'b1;
            end
            if (evt_we) begin
                evt_vld_reg[p1_kidx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_last_vld_reg <= 1'b0;
            evt_last_vld_reg <= 1'b0;
        end else begin
            bin_last_vld_reg <= bin_we;
            evt_last_vld_reg <= evt_we;
        end
    end

    always_comb begin
        sum_b_next = sum_b_reg;
        sum_f_next = sum_f_reg;
        if (p1_vld_reg) begin
            if (p1_clear_reg) begin
                sum_b_next = '0;
                sum_f_next = '0;
            end else if (p1_tick_reg) begin
                sum_b_next = sum_b_reg + SB_W'(bin_a.bytes) - SB_W'(bin_b.bytes);
                sum_f_next = sum_f_reg + SF_W'(bin_a.frames) - SF_W'(bin_b.frames);
            end
        end
    end

    assign sb_wide = 64'(sum_b_next);
    assign sf_wide = 64'(sum_f_next);

    always_comb begin
        side_next.window_bytes  = (sb_wide > 64'(WB_MAX)) ? WB_MAX : WIN_BYTES_W'(sb_wide);
        side_next.window_frames = (sf_wide > 64'(WF_MAX)) ? WF_MAX : WIN_FRAMES_W'(sf_wide);
        side_next.frame_count   = p1_ftotal_reg;
        side_next.byte_count    = p1_btotal_reg;
        if (p1_clear_reg || !p1_kind_ok_reg) begin
            side_next.event_count = '0;
        end else begin
            side_next.event_count = p1_event_reg ? ev_inc : ev;
        end
        side_next.running         = p1_run_reg;
        side_next.bad_sensor      = p1_sensor_reg;
        side_next.connection_lost = p1_lost_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_b_reg   <= '0;
            sum_f_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            sum_b_reg   <= sum_b_next;
            sum_f_reg   <= sum_f_next;
            out_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        side_reg <= side_next;
    end

    assign out_valid      = out_vld_reg;
    assign out_sum_bytes  = sum_b_reg;
    assign out_sum_frames = sum_f_reg;
    assign out_side       = side_reg;

endmodule

`default_nettype wire

// File: rtl/wbfm_fifo.sv
// result queue with credit count that sets the input ready
`default_nettype none

module wbfm_fifo
    import wbfm_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_accept,
    input  wire logic                 wr_valid,
    input  wire logic [M_TDATA_W-1:0] wr_data,
    output logic                      s_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [M_TDATA_W-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] credit_reg, credit_next;
    logic          pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (fill_reg != '0);
    assign m_tdata  = mem[rd_ptr_reg];
    assign s_ready  = (credit_reg < CW'(DEPTH));

    // credit covers results still in flight as well as those queued
    assign fill_next   = fill_reg + CW'(wr_valid) - CW'(pop);
    assign credit_next = credit_reg + CW'(in_accept) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end else begin
            if (wr_valid) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/windowed_bitrate_framerate_meter_unit.sv
// top level of the windowed bit rate and frame rate meter
//
// Counts a video stream in a ring of BINS bins of PERIOD_MS each: frame items add
// their length to the current bin, a tick item closes it and moves on, and the
// window is every bin but the current one. Each transaction on the slave side
// gives exactly one result transaction, reporting the window sums, bit rate in
// Mbit/s with 16 fraction bits, frame rate with 8 fraction bits, saturating totals,
// the count of the event kind named in the item, and the status flags. One item
// is taken every clock while s_tready is high; the bin and event memories are read
// on acceptance and written back in the following cycle with forwarding, and the
// rates come from a four-stage constant divider. Up to eight results are
// buffered, so the input keeps flowing while the output is stalled until that
// many are outstanding.
`default_nettype none

module windowed_bitrate_framerate_meter_unit
    import wbfm_pkg::*;
#(
    parameter int BINS        = 8,
    parameter int PERIOD_MS   = 1000,
    parameter int EVENT_KINDS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // frame_length [23:0], event_kind [26:24]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // command [2:0]
    input  wire logic [CMD_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // window_bytes [34:0], window_frames [61:35], bitrate_mbps_q16 [93:62],
    // framerate_q8 [126:94], frame_count [174:127], byte_count [222:175],
    // event_count [254:223], running [255], bad_sensor [256], connection_lost [257]
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int SB_W      = BIN_BYTES_W + $clog2(BINS);
    localparam int SF_W      = BIN_FRAMES_W + $clog2(BINS);
    localparam int WINDOW_MS = (BINS - 1) * PERIOD_MS;

    logic                   s_accept;
    logic                   core_valid;
    logic [SB_W-1:0]        core_sum_bytes;
    logic [SF_W-1:0]        core_sum_frames;
    side_t                  core_side;
    logic [BITRATE_W-1:0]   bitrate;
    logic [FRAMERATE_W-1:0] framerate;
    side_t                  side_d_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0]  vld_d_reg;
    side_t                  res_side;
    logic [M_TDATA_W-1:0]   res_data;

    assign s_accept = s_tvalid && s_tready;

    wbfm_core #(
        .BINS        (BINS),
        .EVENT_KINDS (EVENT_KINDS),
        .SB_W        (SB_W),
        .SF_W        (SF_W)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_accept      (s_accept),
        .in_cmd         (s_tuser),
        .in_len         (s_tdata[LEN_W-1:0]),
        .in_kind        (s_tdata[LEN_W+KIND_W-1:LEN_W]),
        .out_valid      (core_valid),
        .out_sum_bytes  (core_sum_bytes),
        .out_sum_frames (core_sum_frames),
        .out_side       (core_side)
    );

    wbfm_div #(
        .IN_W  (SB_W),
        .NUM   (BITRATE_NUM),
        .DEN   (WINDOW_MS),
        .OUT_W (BITRATE_W)
    ) u_div_bytes (
        .aclk     (aclk),
        .value    (core_sum_bytes),
        .quotient (bitrate)
    );

    wbfm_div #(
        .IN_W  (SF_W),
        .NUM   (FRAMERATE_NUM),
        .DEN   (WINDOW_MS),
        .OUT_W (FRAMERATE_W)
    ) u_div_frames (
        .aclk     (aclk),
        .value    (core_sum_frames),
        .quotient (framerate)
    );

    // side fields wait for the dividers
    always_ff @(posedge aclk) begin
        side_d_reg[0] <= core_side;
        for (int i = 1; i < DIV_STAGES; i++) begin
            side_d_reg[i] <= side_d_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_d_reg <= '0;
        end else begin
            vld_d_reg <= {vld_d_reg[DIV_STAGES-2:0], core_valid};
        end
    end

    assign res_side = side_d_reg[DIV_STAGES-1];
    assign res_data = {6'd0,
                       res_side.connection_lost,
                       res_side.bad_sensor,
                       res_side.running,
                       res_side.event_count,
                       res_side.byte_count,
                       res_side.frame_count,
                       framerate,
                       bitrate,
                       res_side.window_frames,
                       res_side.window_bytes};

    wbfm_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .wr_valid  (vld_d_reg[DIV_STAGES-1]),
        .wr_data   (res_data),
        .s_ready   (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
